// File: rtl/core/ssu_pkg.sv
// Span union package: status codes, opcodes and the command and status bundles
// exchanged between the controller and the datapath. No dependencies.
`default_nettype none

package ssu_pkg;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_IGN  = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic [10:0] ROW_LIMIT_RST = 11'd1024;

  // source of the count reported with a single-result item
  typedef enum logic [1:0] {
    CNT_ZERO = 2'd0,
    CNT_N    = 2'd1,
    CNT_WR1  = 2'd2
  } cnt_sel_e;

  typedef struct packed {
    logic       load_item;
    logic       clr_step;
    logic       cnt_rd;
    logic       cnt_lat;
    logic       stream_init;
    logic       scan_step;
    logic       merge_step;
    logic       tail;
    logic       ro_rd;
    logic       ro_out;
    logic       done_out;
    logic       res_load;
    logic [1:0] res_status;
    cnt_sel_e   res_cnt;
  } ssu_cmd_t;

  typedef struct packed {
    logic row_ok;
    logic op_ro;
    logic span_ok;
    logic n_zero;
    logic n_full;
    logic stream_end;
    logic found;
    logic ro_last;
    logic out_free;
    logic clr_last;
  } ssu_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ssu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ssu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/ssu_ctrl.sv
// Span union controller: sequences count read, row scan, merge stream and
// readout. Depends on ssu_pkg.
`default_nettype none

module ssu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ssu_pkg::ssu_sts_t sts_i,
  output ssu_pkg::ssu_cmd_t      cmd_o
);

  import ssu_pkg::*;

  typedef enum logic [10:0] {
    S_CLR    = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_CNT    = 11'b000_0000_0100,
    S_LAT    = 11'b000_0000_1000,
    S_DEC    = 11'b000_0001_0000,
    S_SCAN   = 11'b000_0010_0000,
    S_MERGE  = 11'b000_0100_0000,
    S_TAIL   = 11'b000_1000_0000,
    S_DONE   = 11'b001_0000_0000,
    S_RO_RD  = 11'b010_0000_0000,
    S_RO_OUT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_status = ST_DONE;
    cmd_o.res_cnt    = CNT_ZERO;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = S_LAT;
      end
      S_LAT: begin
        cmd_o.cnt_lat = 1'b1;
        state_d       = S_DEC;
      end
      S_DEC: begin
        if (!sts_i.row_ok) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_IGN;
          cmd_o.res_cnt    = CNT_ZERO;
          state_d          = S_DONE;
        end else if (sts_i.op_ro) begin
          if (sts_i.n_zero) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.stream_init = 1'b1;
            state_d           = S_RO_RD;
          end
        end else if (!sts_i.span_ok) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_IGN;
          cmd_o.res_cnt    = CNT_N;
          state_d          = S_DONE;
        end else begin
          cmd_o.stream_init = 1'b1;
          // a full row is checked for an overlap before anything is written
          state_d = sts_i.n_full ? S_SCAN : S_MERGE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.stream_end) begin
          if (sts_i.found) begin
            cmd_o.stream_init = 1'b1;
            state_d           = S_MERGE;
          end else begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_OVF;
            cmd_o.res_cnt    = CNT_N;
            state_d          = S_DONE;
          end
        end
      end
      S_MERGE: begin
        cmd_o.merge_step = 1'b1;
        if (sts_i.stream_end) state_d = S_TAIL;
      end
      S_TAIL: begin
        cmd_o.tail     = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_cnt  = CNT_WR1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RO_RD: begin
        cmd_o.ro_rd = 1'b1;
        state_d     = S_RO_OUT;
      end
      S_RO_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.ro_out = 1'b1;
          state_d      = sts_i.ro_last ? S_IDLE : S_RO_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ssu_dp.sv
// Span union datapath: item registers, span and count RAMs, merge stream,
// result register and row limit register. Depends on ssu_pkg and ssu_ram.
`default_nettype none

module ssu_dp #(
  parameter int ROWS          = 1024,
  parameter int SPANS_PER_ROW = 16,
  parameter int COORD_BITS    = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [10:0]       cfg_row_limit_i,
  input  wire logic              op_i,
  input  wire logic [15:0]       row_i,
  input  wire logic [15:0]       start_x_i,
  input  wire logic [15:0]       end_x_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic [1:0]             status_o,
  output logic                   span_valid_o,
  output logic [15:0]            span_start_o,
  output logic [15:0]            span_end_o,
  output logic [4:0]             span_count_o,
  output logic                   last_o,
  input  wire ssu_pkg::ssu_cmd_t cmd_i,
  output ssu_pkg::ssu_sts_t      sts_o
);

  import ssu_pkg::*;

  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW     = (SPANS_PER_ROW > 1) ? $clog2(SPANS_PER_ROW) : 1;
  localparam int CNTW   = $clog2(SPANS_PER_ROW + 1);
  localparam int CW     = COORD_BITS;
  localparam int SDEPTH = (2 ** RW) * (2 ** SW);
  localparam logic [16:0] ROWS_L = 17'(ROWS);

  // item
  logic                 op_q, row_ok_q, span_ok_q;
  logic [RW-1:0]        row_q;
  logic signed [CW-1:0] x0_q, x1_q, x0_in, x1_in;
  logic [16:0]          lim_ext, lim;
  logic                 row_ok_in;

  // stream
  logic [CNTW-1:0]      n_q, rd_q, wr_q;
  logic                 dv_q, found_q, placed_q;
  logic signed [CW-1:0] ns_x0_q, ns_x1_q, cy_x0_q, cy_x1_q;
  logic signed [CW-1:0] e_x0, e_x1;
  logic                 e_before, e_after, e_overlap, mrg, issue, issue_done, ro_last;

  // memories
  logic                 span_we, span_re;
  logic [2*CW-1:0]      span_wdata, span_rdata;
  logic [RW+SW-1:0]     span_waddr, span_raddr;
  logic                 cnt_we;
  logic [RW-1:0]        cnt_waddr;
  logic [CNTW-1:0]      cnt_wdata, cnt_rdata;

  // control registers
  logic [10:0]          row_limit_q;
  logic [RW-1:0]        clr_q;
  logic                 out_valid_q, out_free;

  // result
  logic [1:0]           res_status_q, out_status_q;
  logic [CNTW-1:0]      res_cnt_q, out_cnt_q;
  logic                 out_span_q, out_last_q;
  logic signed [CW-1:0] out_x0_q, out_x1_q;

  if (CW <= 16) begin : g_cin_narrow
    assign x0_in = start_x_i[CW-1:0];
    assign x1_in = end_x_i[CW-1:0];
  end else begin : g_cin_wide
    assign x0_in = {{(CW-16){1'b0}}, start_x_i};
    assign x1_in = {{(CW-16){1'b0}}, end_x_i};
  end

  assign lim_ext   = {6'd0, row_limit_q};
  assign lim       = (lim_ext < ROWS_L) ? lim_ext : ROWS_L;
  assign row_ok_in = !row_i[15] && ({1'b0, row_i} < lim);

  assign e_x0      = span_rdata[2*CW-1:CW];
  assign e_x1      = span_rdata[CW-1:0];
  assign e_before  = (e_x1 < ns_x0_q);
  assign e_after   = (e_x0 > ns_x1_q);
  assign e_overlap = !e_before && !e_after;
  assign mrg       = cmd_i.merge_step && dv_q;

  assign issue_done = (rd_q == n_q);
  assign issue      = (cmd_i.scan_step || cmd_i.merge_step) && !issue_done;
  assign ro_last    = (({1'b0, rd_q} + 1'b1) == {1'b0, n_q});
  assign out_free   = !out_valid_q || !out_stall_i;

  // one write per cycle: the slot at wr_q never runs ahead of the read pointer
  always_comb begin
    span_we    = 1'b0;
    span_wdata = {ns_x0_q, ns_x1_q};
    if (mrg) begin
      if (placed_q) begin
        span_we    = 1'b1;
        span_wdata = {cy_x0_q, cy_x1_q};
      end else if (e_before) begin
        span_we    = 1'b1;
        span_wdata = {e_x0, e_x1};
      end else if (e_after) begin
        span_we    = 1'b1;
        span_wdata = {ns_x0_q, ns_x1_q};
      end
    end
    if (cmd_i.tail) begin
      span_we    = 1'b1;
      span_wdata = placed_q ? {cy_x0_q, cy_x1_q} : {ns_x0_q, ns_x1_q};
    end
  end

  assign span_waddr = {row_q, wr_q[SW-1:0]};
  assign span_raddr = {row_q, rd_q[SW-1:0]};
  assign span_re    = issue || cmd_i.ro_rd;

  assign cnt_we    = cmd_i.clr_step || cmd_i.tail || (cmd_i.ro_out && ro_last);
  assign cnt_waddr = cmd_i.clr_step ? clr_q : row_q;
  assign cnt_wdata = cmd_i.tail ? (wr_q + CNTW'(1)) : '0;

  ssu_ram #(
    .WIDTH (2 * CW),
    .DEPTH (SDEPTH)
  ) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (span_we),
    .waddr_i (span_waddr),
    .wdata_i (span_wdata),
    .re_i    (span_re),
    .raddr_i (span_raddr),
    .rdata_o (span_rdata)
  );

  ssu_ram #(
    .WIDTH (CNTW),
    .DEPTH (ROWS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.cnt_rd),
    .raddr_i (row_q),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_limit_q <= ROW_LIMIT_RST;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) row_limit_q <= cfg_row_limit_i;
      if (cmd_i.clr_step) clr_q <= clr_q + RW'(1);
      if (cmd_i.done_out || cmd_i.ro_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      dv_q <= cmd_i.stream_init ? 1'b0 : issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q      <= op_i;
      row_q     <= row_i[RW-1:0];
      row_ok_q  <= row_ok_in;
      span_ok_q <= (x0_in < x1_in);
      x0_q      <= x0_in;
      x1_q      <= x1_in;
    end
    if (cmd_i.cnt_lat) n_q <= cnt_rdata;
    if (cmd_i.stream_init) begin
      rd_q     <= '0;
      wr_q     <= '0;
      found_q  <= 1'b0;
      placed_q <= 1'b0;
      ns_x0_q  <= x0_q;
      ns_x1_q  <= x1_q;
    end else begin
      if (issue || cmd_i.ro_out) rd_q <= rd_q + CNTW'(1);
      if (span_we) wr_q <= wr_q + CNTW'(1);
      if (cmd_i.scan_step && dv_q && e_overlap) found_q <= 1'b1;
      if (mrg) begin
        if (placed_q || e_after) begin
          cy_x0_q <= e_x0;
          cy_x1_q <= e_x1;
        end
        if (!placed_q && e_after) placed_q <= 1'b1;
        if (!placed_q && e_overlap) begin
          ns_x0_q <= (e_x0 < ns_x0_q) ? e_x0 : ns_x0_q;
          ns_x1_q <= (e_x1 > ns_x1_q) ? e_x1 : ns_x1_q;
        end
      end
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      case (cmd_i.res_cnt)
        CNT_ZERO: res_cnt_q <= '0;
        CNT_N:    res_cnt_q <= n_q;
        CNT_WR1:  res_cnt_q <= wr_q + CNTW'(1);
        default:  res_cnt_q <= '0;
      endcase
    end
    if (cmd_i.done_out) begin
      out_status_q <= res_status_q;
      out_span_q   <= 1'b0;
      out_x0_q     <= '0;
      out_x1_q     <= '0;
      out_cnt_q    <= res_cnt_q;
      out_last_q   <= 1'b1;
    end else if (cmd_i.ro_out) begin
      out_status_q <= ST_DONE;
      out_span_q   <= 1'b1;
      out_x0_q     <= e_x0;
      out_x1_q     <= e_x1;
      out_cnt_q    <= '0;
      out_last_q   <= ro_last;
    end
  end

  if (CW >= 16) begin : g_cout_wide
    assign span_start_o = out_x0_q[15:0];
    assign span_end_o   = out_x1_q[15:0];
  end else begin : g_cout_narrow
    assign span_start_o = {{(16-CW){out_x0_q[CW-1]}}, out_x0_q};
    assign span_end_o   = {{(16-CW){out_x1_q[CW-1]}}, out_x1_q};
  end

  if (CNTW >= 5) begin : g_cnt_trunc
    assign span_count_o = out_cnt_q[4:0];
  end else begin : g_cnt_ext
    assign span_count_o = {{(5-CNTW){1'b0}}, out_cnt_q};
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign span_valid_o = out_span_q;
  assign last_o       = out_last_q;

  assign sts_o.row_ok     = row_ok_q;
  assign sts_o.op_ro      = (op_q == OP_READOUT);
  assign sts_o.span_ok    = span_ok_q;
  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.n_full     = (n_q == CNTW'(SPANS_PER_ROW));
  assign sts_o.stream_end = issue_done && !dv_q;
  assign sts_o.found      = found_q;
  assign sts_o.ro_last    = ro_last;
  assign sts_o.out_free   = out_free;
  assign sts_o.clr_last   = (clr_q == RW'(ROWS - 1));

endmodule

`default_nettype wire

// File: rtl/core/scanline_span_union.sv
// Top level of the scanline span union: controller plus datapath.
// Depends on ssu_pkg, ssu_ctrl, ssu_dp (and ssu_ram below it).
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------------
//   in      | in        | in_valid_i / in_stall_o   | op, row, start_x, end_x
//   out     | out       | out_valid_o / out_stall_i | status, span_valid, span_start/end, count, last
//   cfg     | in        | cfg_valid_i / cfg_ready_o | row_limit
//
// Insert: the merge streams the row through the span RAM, one read and at most one
// write a cycle. A full row first takes an overlap scan; an overflow ends right
// after it. Readout reads and emits the spans of the row in turn. An ignored item
// or an empty readout gives a single result and streams nothing. After reset the
// row counts are cleared one row a cycle and in_stall_o stays high meanwhile.
// A stalled output holds the work at the next emit; the next item is taken while
// the last result is still waiting.
`default_nettype none

module scanline_span_union #(
  parameter int ROWS          = 1024,
  parameter int SPANS_PER_ROW = 16,
  parameter int COORD_BITS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_row_limit_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [15:0] row_i,
  input  wire logic [15:0] start_x_i,
  input  wire logic [15:0] end_x_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             span_valid_o,
  output logic [15:0]      span_start_o,
  output logic [15:0]      span_end_o,
  output logic [4:0]       span_count_o,
  output logic             last_o
);

  import ssu_pkg::*;

  ssu_cmd_t cmd;
  ssu_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ssu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssu_dp #(
    .ROWS          (ROWS),
    .SPANS_PER_ROW (SPANS_PER_ROW),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_row_limit_i (cfg_row_limit_i),
    .op_i            (op_i),
    .row_i           (row_i),
    .start_x_i       (start_x_i),
    .end_x_i         (end_x_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .span_valid_o    (span_valid_o),
    .span_start_o    (span_start_o),
    .span_end_o      (span_end_o),
    .span_count_o    (span_count_o),
    .last_o          (last_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

// File: rtl/core/ssu_checker.sv
// Port-level checks for scanline_span_union, bound to the top level.
// Depends on ssu_pkg.
`default_nettype none

module ssu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] status_o,
  input wire logic       span_valid_o,
  input wire logic [4:0] span_count_o
);

  import ssu_pkg::*;

  // one item at a time: an accepted item closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(span_count_o))
    else $error("stalled result changed");

  a_span_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && span_valid_o |-> status_o == ST_DONE && span_count_o == 5'd0)
    else $error("readout span with bad status or count");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_DONE || status_o == ST_IGN || status_o == ST_OVF)
    else $error("undefined status code");

endmodule

bind scanline_span_union ssu_checker u_ssu_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for scanline_span_union: directed table then random span bursts,
// every result checked against a local row/span predictor or a hand-written answer. Needs ssu_pkg.
`timescale 1ns / 100ps

module tb_top;
  import ssu_pkg::*;

  localparam int NROWS = 1024;
  localparam int NSPAN = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid;
    logic [15:0] sx;
    logic [15:0] ex;
    logic [4:0]  count;
    logic        last;
  } span_res_t;

  typedef struct packed {
    logic        op;
    logic [15:0] row;
    logic [15:0] sx;
    logic [15:0] ex;
    logic        typed;
    logic [1:0]  status;
    logic [4:0]  count;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [10:0] cfg_limit = '0;
  logic        in_valid = 1'b0;
  logic        op = 1'b0;
  logic [15:0] row = '0, sx = '0, ex = '0;
  logic        out_stall = 1'b0;
  wire         cfg_ready, in_stall, out_valid, span_valid, last;
  wire  [1:0]  status;
  wire  [15:0] span_start, span_end;
  wire  [4:0]  span_count;

  scanline_span_union dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_row_limit_i(cfg_limit),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .row_i(row), .start_x_i(sx), .end_x_i(ex),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .span_valid_o(span_valid), .span_start_o(span_start),
    .span_end_o(span_end), .span_count_o(span_count), .last_o(last)
  );

  always #5 clk = ~clk;

  // predictor state
  int span_lo[NROWS][NSPAN];
  int span_hi[NROWS][NSPAN];
  int spans_in_row[NROWS];
  int row_lim = 1024;
  span_res_t expected_spans[$];
  int mismatches = 0;
  bit calm = 1'b0;

  task automatic add_expect(span_res_t r);
    expected_spans = {expected_spans, r};
  endtask

  function automatic logic [1:0] add_span(int r, int a, int b);
    int n, i, j, k, pos;
    n = spans_in_row[r];
    pos = -1;
    if (n == 0 || a > span_hi[r][n-1]) pos = n;
    else if (b < span_lo[r][0]) pos = 0;
    else begin
      for (i = 0; i < n; i++) begin
        if (b >= span_lo[r][i] && a <= span_hi[r][i]) begin
          if (a < span_lo[r][i]) span_lo[r][i] = a;
          if (b > span_hi[r][i]) begin
            k = i + 1;
            while (k < n && span_lo[r][k] <= b) k++;
            k--;
            span_hi[r][i] = (b > span_hi[r][k]) ? b : span_hi[r][k];
            if (k != i) begin
              // close the hole left by the swallowed spans
              for (j = i + 1; j + (k - i) < n; j++) begin
                span_lo[r][j] = span_lo[r][j + k - i];
                span_hi[r][j] = span_hi[r][j + k - i];
              end
              n -= k - i;
            end
          end
          spans_in_row[r] = n;
          return ST_DONE;
        end else if (a < span_lo[r][i]) begin
          pos = i;
          break;
        end
      end
      if (pos < 0) return ST_DONE;
    end
    if (n >= NSPAN) return ST_OVF;
    for (j = n; j > pos; j--) begin
      span_lo[r][j] = span_lo[r][j-1];
      span_hi[r][j] = span_hi[r][j-1];
    end
    span_lo[r][pos] = a;
    span_hi[r][pos] = b;
    spans_in_row[r] = n + 1;
    return ST_DONE;
  endfunction

  task automatic predict_item(stim_row_t s);
    int r, a, b, n, i, lim;
    logic [1:0] st;
    r = $signed(s.row);
    a = $signed(s.sx);
    b = $signed(s.ex);
    lim = (row_lim > NROWS) ? NROWS : row_lim;
    if (r < 0 || r >= lim) begin
      add_expect('{ST_IGN, 1'b0, 16'd0, 16'd0, 5'd0, 1'b1});
    end else if (s.op == OP_INSERT) begin
      if (a >= b) st = ST_IGN;
      else st = add_span(r, a, b);
      add_expect('{st, 1'b0, 16'd0, 16'd0, 5'(spans_in_row[r]), 1'b1});
    end else begin
      n = spans_in_row[r];
      spans_in_row[r] = 0;
      if (n == 0) add_expect('{ST_DONE, 1'b0, 16'd0, 16'd0, 5'd0, 1'b1});
      for (i = 0; i < n; i++)
        add_expect('{ST_DONE, 1'b1, 16'(span_lo[r][i]), 16'(span_hi[r][i]),
                     5'd0, (i == n - 1)});
    end
    if (s.typed) begin
      // directed row with a hand-written answer overrides the prediction
      void'(expected_spans.pop_back());
      add_expect('{s.status, 1'b0, 16'd0, 16'd0, s.count, 1'b1});
    end
  endtask

  task automatic send_item(stim_row_t s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= s.op;
    row <= s.row;
    sx <= s.sx;
    ex <= s.ex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(s);
  endtask

  task automatic write_limit(logic [10:0] v);
    in_valid <= 1'b0;
    wait (expected_spans.size() == 0);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    row_lim = v;
  endtask

  function automatic stim_row_t mk(logic o, int r, int a, int b);
    return '{o, 16'(r), 16'(a), 16'(b), 1'b0, 2'd0, 5'd0};
  endfunction

  function automatic stim_row_t mk_typed(logic o, int r, int a, int b,
                                         logic [1:0] st, int c);
    return '{o, 16'(r), 16'(a), 16'(b), 1'b1, st, 5'(c)};
  endfunction

  // bursts of narrow spans into a few rows, then a readout; some noise
  task automatic random_phase(int items);
    int done_cnt, r, m, j, base, lim;
    lim = (row_lim > NROWS) ? NROWS : row_lim;
    done_cnt = 0;
    calm = ($urandom_range(0, 3) == 0);
    while (done_cnt < items) begin
      if ($urandom_range(0, 9) == 0 || lim == 0) begin
        send_item('{1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom),
                    1'b0, 2'd0, 5'd0});
        done_cnt++;
      end else begin
        r = ($urandom_range(0, 4) == 0) ? lim - 1 : $urandom_range(0, (lim < 4) ? lim - 1 : 3);
        m = $urandom_range(1, 22);
        for (j = 0; j < m; j++) begin
          base = $urandom_range(0, 40) * 4 - 80;
          if ($urandom_range(0, 7) == 0)
            send_item(mk(OP_INSERT, r, $signed(16'($urandom)), $signed(16'($urandom))));
          else
            send_item(mk(OP_INSERT, r, base, base + $urandom_range(0, 5)));
        end
        send_item(mk(OP_READOUT, r, $urandom, $urandom));
        done_cnt += m + 1;
      end
    end
    calm = 1'b0;
  endtask

  stim_row_t directed[] = '{
    mk_typed(OP_READOUT, 3, 0, 0, ST_DONE, 0),
    mk_typed(OP_INSERT, -1, 0, 10, ST_IGN, 0),
    mk_typed(OP_INSERT, 1024, 0, 10, ST_IGN, 0),
    mk_typed(OP_INSERT, -32768, 0, 10, ST_IGN, 0),
    mk_typed(OP_INSERT, 32767, 0, 10, ST_IGN, 0),
    mk_typed(OP_INSERT, 0, 10, 20, ST_DONE, 1),
    mk_typed(OP_INSERT, 0, 5, 5, ST_IGN, 1),
    mk_typed(OP_INSERT, 0, 30, 20, ST_IGN, 1),
    mk(OP_INSERT, 0, 30, 40),
    mk(OP_INSERT, 0, 0, 5),
    mk(OP_INSERT, 0, 20, 30),
    mk(OP_INSERT, 0, 50, 60),
    mk(OP_INSERT, 0, 45, 47),
    mk(OP_INSERT, 0, 4, 6),
    mk(OP_READOUT, 0, 0, 0),
    mk(OP_INSERT, 0, -32768, 32767),
    mk(OP_INSERT, 0, 100, 200),
    mk(OP_READOUT, 0, 12345, -1),
    mk(OP_INSERT, 1023, -32768, -32767),
    mk(OP_INSERT, 1023, 32766, 32767),
    mk(OP_READOUT, 1023, -32768, 32767),
    mk_typed(OP_READOUT, 0, 0, 0, ST_DONE, 0),
    mk_typed(OP_READOUT, -1, 0, 0, ST_IGN, 0)
  };

  // output stall: random hold per accepted result
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall && !calm) stall_left <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    span_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{status, span_valid, span_start, span_end, span_count, last};
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        want = expected_spans.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i]);
    write_limit(11'd2047);
    random_phase(50);
    write_limit(11'd0);
    random_phase(10);
    write_limit(11'd3);
    random_phase(45);
    write_limit(11'd1);
    random_phase(25);
    write_limit(11'd1023);
    random_phase(40);
    write_limit(11'd1024);
    random_phase(25);
    in_valid <= 1'b0;
    wait (expected_spans.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
